[rtl/space_vector_pwm_duty_top_assert.svh]
// Assertion macros for the space vector PWM duty block.
// Used by the port checker; needs clk_i and rst_ni in scope.
`ifndef SPACE_VECTOR_PWM_DUTY_TOP_ASSERT_SVH
`define SPACE_VECTOR_PWM_DUTY_TOP_ASSERT_SVH

// same-cycle implication
`define SVPWM_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("svpwm assertion failed");

// next-cycle implication
`define SVPWM_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("svpwm assertion failed");

`endif

[rtl/svpwm_pkg.sv]
// Shared widths, constants and the sector decode for the SVPWM duty block.
// No dependencies.
package svpwm_pkg;

  localparam int VOLTAGE_WIDTH = 16;
  localparam int DUTY_WIDTH    = 16;
  localparam int BUS_WIDTH     = VOLTAGE_WIDTH - 1;
  localparam int SQRT3_FRAC    = 29;
  localparam int SQRT3_W       = 30;
  localparam logic [SQRT3_W-1:0] SQRT3_Q29 = 30'd929887697;
  // quotient width of the X/Y/Z dividers
  localparam int QUO_WIDTH     = VOLTAGE_WIDTH + DUTY_WIDTH + 1;
  localparam int ONE           = 1 << DUTY_WIDTH;
  localparam int ZERO_VEC_DUTY = 3 << (DUTY_WIDTH - 2);

  typedef logic [2:0] sector_t;

  localparam sector_t SEC_ZERO = 3'd0;
  localparam sector_t SEC_1    = 3'd1;
  localparam sector_t SEC_2    = 3'd2;
  localparam sector_t SEC_3    = 3'd3;
  localparam sector_t SEC_4    = 3'd4;
  localparam sector_t SEC_5    = 3'd5;
  localparam sector_t SEC_6    = 3'd6;

  // code = {sqrt3*(-a) > b, sqrt3*a > b, b > 0}
  function automatic sector_t sector_of_code(logic [2:0] code);
    sector_t s;
    unique case (code)
      3'b001:  s = SEC_2;
      3'b010:  s = SEC_6;
      3'b011:  s = SEC_1;
      3'b100:  s = SEC_4;
      3'b101:  s = SEC_3;
      3'b110:  s = SEC_5;
      default: s = SEC_ZERO;
    endcase
    return s;
  endfunction

endpackage

[rtl/svpwm_div.sv]
// Pipelined restoring divider, one quotient bit per stage.
// Depends on svpwm_pkg.
module svpwm_div (
  input  logic                             clk_i,
  input  logic                             en_i,
  input  logic [svpwm_pkg::QUO_WIDTH-1:0]  num_i,
  input  logic [svpwm_pkg::BUS_WIDTH-1:0]  den_i,
  output logic [svpwm_pkg::QUO_WIDTH-1:0]  quo_o
);
  import svpwm_pkg::*;

  localparam int WW = BUS_WIDTH + 1 + QUO_WIDTH;

  logic [WW-1:0]        w_q [QUO_WIDTH];
  logic [BUS_WIDTH-1:0] d_q [QUO_WIDTH-1];

  genvar i;
  generate
    for (i = 0; i < QUO_WIDTH; i++) begin : g_stage
      logic [WW-1:0]        w_in;
      logic [WW-1:0]        w_sh;
      logic [BUS_WIDTH-1:0] d_in;
      logic [BUS_WIDTH:0]   rem;

      if (i == 0) begin : g_first
        assign w_in = {(BUS_WIDTH + 1)'(0), num_i};
        assign d_in = den_i;
      end else begin : g_next
        assign w_in = w_q[i-1];
        assign d_in = d_q[i-1];
      end

      assign w_sh = w_in << 1;
      assign rem  = w_sh[WW-1:QUO_WIDTH];

      always_ff @(posedge clk_i) begin
        if (en_i) begin
          if (rem >= {1'b0, d_in}) begin
            w_q[i] <= {rem - {1'b0, d_in}, w_sh[QUO_WIDTH-1:1], 1'b1};
          end else begin
            w_q[i] <= w_sh;
          end
        end
      end

      if (i < QUO_WIDTH - 1) begin : g_den
        always_ff @(posedge clk_i) begin
          if (en_i) begin
            d_q[i] <= d_in;
          end
        end
      end
    end
  endgenerate

  assign quo_o = w_q[QUO_WIDTH-1][QUO_WIDTH-1:0];

endmodule

[rtl/space_vector_pwm_duty_top.sv]
// Space vector PWM duty computation, seven-segment, deep pipeline.
// Depends on svpwm_pkg and svpwm_div.
//
//  channel | handshake              | payload
//  --------+------------------------+-------------------------------------------
//  in      | in_valid_i / in_ready_o | alpha_voltage_i, beta_voltage_i, bus_voltage_i
//  out     | out_valid_o/out_ready_i | duty_a_o, duty_b_o, duty_c_o, sector_o,
//          |                        | overmodulated_o
//
// One beat enters per cycle while the output is not stalled; the pipeline depth
// is set by the bit-per-stage X/Y/Z dividers and the bit-per-stage
// overmodulation ratio divider.
// All stages advance together; a stalled output freezes the whole pipe, so no
// beat is dropped or repeated. in_ready_o follows the output slot.
// Reset clears only the valid bits; no clearing pass is needed.
module space_vector_pwm_duty_top (
  input  logic                                       clk_i,
  input  logic                                       rst_ni,
  input  logic                                       in_valid_i,
  output logic                                       in_ready_o,
  input  logic signed [svpwm_pkg::VOLTAGE_WIDTH-1:0] alpha_voltage_i,
  input  logic signed [svpwm_pkg::VOLTAGE_WIDTH-1:0] beta_voltage_i,
  input  logic        [svpwm_pkg::BUS_WIDTH-1:0]     bus_voltage_i,
  output logic                                       out_valid_o,
  input  logic                                       out_ready_i,
  output logic        [svpwm_pkg::DUTY_WIDTH-1:0]    duty_a_o,
  output logic        [svpwm_pkg::DUTY_WIDTH-1:0]    duty_b_o,
  output logic        [svpwm_pkg::DUTY_WIDTH-1:0]    duty_c_o,
  output logic        [2:0]                          sector_o,
  output logic                                       overmodulated_o
);
  import svpwm_pkg::*;

  localparam int VW     = VOLTAGE_WIDTH;
  localparam int DW     = DUTY_WIDTH;
  localparam int QW     = QUO_WIDTH;
  localparam int PW     = SQRT3_W + 1 + VW;   // sqrt3*b product
  localparam int NW     = VW + 32;            // X/Y/Z numerators
  localparam int SQW    = 2 * VW + 2;         // 3*a^2 compare
  localparam int XSH    = SQRT3_FRAC - DW;    // X divisor shift
  localparam int YSH    = SQRT3_FRAC + 1 - DW;
  localparam int SW     = QW + 1;             // T1 + T2
  localparam int RW     = SW + 1;             // ratio remainder

  // Global advance: the pipe moves whenever the output slot is free or taken.
  logic en;
  assign en         = !out_valid_o || out_ready_i;
  assign in_ready_o = en;

  // ---------------- stage 1: products and magnitudes ----------------
  logic [VW-1:0]        a_u, b_u, a_mag, b_mag;
  logic signed [PW-1:0] sb_d;
  logic [VW+1:0]        a3_d;
  logic [BUS_WIDTH-1:0] v_fix;

  assign a_u   = alpha_voltage_i;
  assign b_u   = beta_voltage_i;
  assign a_mag = a_u[VW-1] ? (~a_u + 1'b1) : a_u;
  assign b_mag = b_u[VW-1] ? (~b_u + 1'b1) : b_u;
  assign sb_d  = $signed({1'b0, SQRT3_Q29}) * beta_voltage_i;
  assign a3_d  = {{2{a_u[VW-1]}}, a_u} + {a_u[VW-1], a_u, 1'b0};
  // zero bus voltage is treated as one
  assign v_fix = (bus_voltage_i == '0) ? BUS_WIDTH'(1) : bus_voltage_i;

  logic                 v1_q;
  logic signed [PW-1:0] sb1_q;
  logic signed [VW+1:0] a31_q;
  logic [2*VW-1:0]      asq1_q, bsq1_q;
  logic                 apos1_q, aneg1_q, bpos1_q, bneg1_q;
  logic [BUS_WIDTH-1:0] v1b_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      sb1_q   <= sb_d;
      a31_q   <= a3_d;
      asq1_q  <= a_mag * a_mag;
      bsq1_q  <= b_mag * b_mag;
      apos1_q <= !a_u[VW-1] && (a_u != '0);
      aneg1_q <= a_u[VW-1];
      bpos1_q <= !b_u[VW-1] && (b_u != '0);
      bneg1_q <= b_u[VW-1];
      v1b_q   <= v_fix;
    end
  end

  // ---------------- stage 2: sector, Y/Z numerators ----------------
  logic [SQW-1:0]       asq3, bsqw;
  logic                 gt_pos, gt_neg;
  logic signed [NW-1:0] sbw, a3sh;

  assign asq3 = SQW'(asq1_q) + (SQW'(asq1_q) << 1);
  assign bsqw = SQW'(bsq1_q);
  // exact sqrt3*x > b tests, x = a and x = -a
  assign gt_pos = apos1_q ? (bneg1_q || (asq3 > bsqw)) : (bneg1_q && (asq3 < bsqw));
  assign gt_neg = aneg1_q ? (bneg1_q || (asq3 > bsqw)) : (bneg1_q && (asq3 < bsqw));
  assign sbw    = NW'(sb1_q);
  assign a3sh   = NW'(a31_q) <<< SQRT3_FRAC;

  logic                 v2_q;
  sector_t              sec2_q;
  logic signed [NW-1:0] nx2_q, ny2_q, nz2_q;
  logic [BUS_WIDTH-1:0] v2b_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      sec2_q <= sector_of_code({gt_neg, gt_pos, bpos1_q});
      nx2_q  <= sbw;
      ny2_q  <= sbw + a3sh;
      nz2_q  <= sbw - a3sh;
      v2b_q  <= v1b_q;
    end
  end

  // ---------------- stage 3: rounding offset and pre-shift ----------------
  // round half away from zero: (|n| + d/2) / d, the low shift bits of d drop out
  logic [NW-1:0] mx, my, mz;
  logic [NW:0]   tx, ty, tz;

  assign mx = nx2_q[NW-1] ? (~nx2_q + 1'b1) : nx2_q;
  assign my = ny2_q[NW-1] ? (~ny2_q + 1'b1) : ny2_q;
  assign mz = nz2_q[NW-1] ? (~nz2_q + 1'b1) : nz2_q;
  assign tx = {1'b0, mx} + ((NW + 1)'(v2b_q) << (XSH - 1));
  assign ty = {1'b0, my} + ((NW + 1)'(v2b_q) << (YSH - 1));
  assign tz = {1'b0, mz} + ((NW + 1)'(v2b_q) << (YSH - 1));

  logic                 v3_q;
  sector_t              sec3_q;
  logic                 sx3_q, sy3_q, sz3_q;
  logic [QW-1:0]        numx3_q, numy3_q, numz3_q;
  logic [BUS_WIDTH-1:0] v3b_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      sec3_q  <= sec2_q;
      sx3_q   <= nx2_q[NW-1];
      sy3_q   <= ny2_q[NW-1];
      sz3_q   <= nz2_q[NW-1];
      numx3_q <= tx[XSH+QW-1:XSH];
      numy3_q <= ty[YSH+QW-1:YSH];
      numz3_q <= tz[YSH+QW-1:YSH];
      v3b_q   <= v2b_q;
    end
  end

  // ---------------- X/Y/Z dividers ----------------
  logic [QW-1:0] qx, qy, qz;

  svpwm_div u_div_x (.clk_i, .en_i(en), .num_i(numx3_q), .den_i(v3b_q), .quo_o(qx));
  svpwm_div u_div_y (.clk_i, .en_i(en), .num_i(numy3_q), .den_i(v3b_q), .quo_o(qy));
  svpwm_div u_div_z (.clk_i, .en_i(en), .num_i(numz3_q), .den_i(v3b_q), .quo_o(qz));

  typedef struct packed {
    sector_t sec;
    logic    sx;
    logic    sy;
    logic    sz;
  } div_side_t;

  logic [QW-1:0] dv_q;
  div_side_t     ds_q [QW];

  always_ff @(posedge clk_i) begin
    if (en) begin
      ds_q[0] <= '{sec: sec3_q, sx: sx3_q, sy: sy3_q, sz: sz3_q};
      for (int k = 1; k < QW; k++) begin
        ds_q[k] <= ds_q[k-1];
      end
    end
  end

  // ---------------- stage 4: active times by sector ----------------
  // sign of each term is known, so a negative time is simply zero
  div_side_t     dsl;
  logic [QW-1:0] t1_c, t2_c;

  assign dsl = ds_q[QW-1];

  always_comb begin
    t1_c = '0;
    t2_c = '0;
    case (dsl.sec)
      SEC_1: begin
        t1_c = dsl.sz ? qz : '0;
        t2_c = dsl.sx ? '0 : qx;
      end
      SEC_2: begin
        t1_c = dsl.sz ? '0 : qz;
        t2_c = dsl.sy ? '0 : qy;
      end
      SEC_3: begin
        t1_c = dsl.sx ? '0 : qx;
        t2_c = dsl.sy ? qy : '0;
      end
      SEC_4: begin
        t1_c = dsl.sx ? qx : '0;
        t2_c = dsl.sz ? '0 : qz;
      end
      SEC_5: begin
        t1_c = dsl.sy ? qy : '0;
        t2_c = dsl.sz ? qz : '0;
      end
      SEC_6: begin
        t1_c = dsl.sy ? '0 : qy;
        t2_c = dsl.sx ? qx : '0;
      end
      default: begin
        t1_c = '0;
        t2_c = '0;
      end
    endcase
  end

  logic          v4_q;
  sector_t       sec4_q;
  logic [QW-1:0] t14_q, t24_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      sec4_q <= dsl.sec;
      t14_q  <= t1_c;
      t24_q  <= t2_c;
    end
  end

  // ---------------- stage 5: sum and overmodulation flag ----------------
  logic [SW-1:0] s_c;
  assign s_c = SW'(t14_q) + SW'(t24_q);

  typedef struct packed {
    sector_t       sec;
    logic          ov;
    logic          ge;    // T1 >= sum, ratio is exactly one
    logic [DW:0]   t1lo;
    logic [DW:0]   t2lo;
    logic [SW-1:0] s;
  } fr_side_t;

  logic          v5_q;
  fr_side_t      fs5_q;
  logic [QW-1:0] t15_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      fs5_q <= '{sec: sec4_q, ov: (s_c > SW'(ONE)), ge: (t24_q == '0),
                 t1lo: t14_q[DW:0], t2lo: t24_q[DW:0], s: s_c};
      t15_q <= t14_q;
    end
  end

  // ---------------- ratio divider: T1 * ONE / (T1 + T2) ----------------
  logic [DW-1:0] fv_q;
  logic [RW-1:0] fr_r_q [DW];
  logic [DW-1:0] fr_qt_q [DW];
  fr_side_t      fr_s_q [DW];

  genvar g;
  generate
    for (g = 0; g < DW; g++) begin : g_frac
      logic [RW-1:0] r_in, r_sh;
      logic [DW-1:0] q_in;
      fr_side_t      s_in;

      if (g == 0) begin : g_first
        assign r_in = RW'(t15_q);
        assign q_in = '0;
        assign s_in = fs5_q;
      end else begin : g_next
        assign r_in = fr_r_q[g-1];
        assign q_in = fr_qt_q[g-1];
        assign s_in = fr_s_q[g-1];
      end

      assign r_sh = r_in << 1;

      always_ff @(posedge clk_i) begin
        if (en) begin
          if (r_sh >= RW'(s_in.s)) begin
            fr_r_q[g]  <= r_sh - RW'(s_in.s);
            fr_qt_q[g] <= {q_in[DW-2:0], 1'b1};
          end else begin
            fr_r_q[g]  <= r_sh;
            fr_qt_q[g] <= {q_in[DW-2:0], 1'b0};
          end
          fr_s_q[g] <= s_in;
        end
      end
    end
  endgenerate

  // ---------------- stage 6: round half up, pick T1 ----------------
  fr_side_t      fl;
  logic [RW:0]   r2;
  logic          rnd;
  logic [DW:0]   t1f_c;

  assign fl    = fr_s_q[DW-1];
  assign r2    = {fr_r_q[DW-1], 1'b0};
  assign rnd   = r2 >= (RW + 1)'(fl.s);
  assign t1f_c = !fl.ov ? fl.t1lo :
                 (fl.ge ? (DW + 1)'(ONE) : ((DW + 1)'(fr_qt_q[DW-1]) + (DW + 1)'(rnd)));

  logic        v6_q;
  sector_t     sec6_q;
  logic        ov6_q;
  logic [DW:0] t16_q, t2lo6_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      sec6_q  <= fl.sec;
      ov6_q   <= fl.ov;
      t16_q   <= t1f_c;
      t2lo6_q <= fl.t2lo;
    end
  end

  // ---------------- stage 7: T2 as the complement when scaled ----------------
  logic        v7_q;
  sector_t     sec7_q;
  logic        ov7_q;
  logic [DW:0] t17_q, t27_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      sec7_q <= sec6_q;
      ov7_q  <= ov6_q;
      t17_q  <= t16_q;
      t27_q  <= ov6_q ? ((DW + 1)'(ONE) - t16_q) : t2lo6_q;
    end
  end

  // ---------------- stage 8: switching points ----------------
  // ta = 1 - T1 - T2, tb = ta + 2 T1, tc = tb + 2 T2
  logic [DW+1:0] t1w, t2w;
  assign t1w = (DW + 2)'(t17_q);
  assign t2w = (DW + 2)'(t27_q);

  logic          v8_q;
  sector_t       sec8_q;
  logic          ov8_q;
  logic [DW+1:0] ta8_q, tb8_q, tc8_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      sec8_q <= sec7_q;
      ov8_q  <= ov7_q;
      ta8_q  <= (DW + 2)'(ONE) - t1w - t2w;
      tb8_q  <= (DW + 2)'(ONE) + t1w - t2w;
      tc8_q  <= (DW + 2)'(ONE) + t1w + t2w;
    end
  end

  // ---------------- stage 9: duties, routing, output register ----------------
  function automatic logic [DW-1:0] duty_of(logic [DW+1:0] t);
    logic [DW+2:0] d;
    logic [DW:0]   h;
    d = (DW + 3)'(4 * ONE + 2) - (DW + 3)'(t);
    h = d[DW+2:2];
    return h[DW] ? {DW{1'b1}} : h[DW-1:0];
  endfunction

  logic [DW-1:0] da, db, dc, pa, pb, pc;
  assign pa = duty_of(ta8_q);
  assign pb = duty_of(tb8_q);
  assign pc = duty_of(tc8_q);

  always_comb begin
    case (sec8_q)
      SEC_2:   begin da = pb; db = pa; dc = pc; end
      SEC_3:   begin da = pc; db = pa; dc = pb; end
      SEC_4:   begin da = pc; db = pb; dc = pa; end
      SEC_5:   begin da = pb; db = pc; dc = pa; end
      SEC_6:   begin da = pa; db = pc; dc = pb; end
      default: begin da = pa; db = pb; dc = pc; end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      duty_a_o        <= da;
      duty_b_o        <= db;
      duty_c_o        <= dc;
      sector_o        <= sec8_q;
      overmodulated_o <= ov8_q;
    end
  end

  // ---------------- valid bits ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      v3_q        <= 1'b0;
      dv_q        <= '0;
      v4_q        <= 1'b0;
      v5_q        <= 1'b0;
      fv_q        <= '0;
      v6_q        <= 1'b0;
      v7_q        <= 1'b0;
      v8_q        <= 1'b0;
      out_valid_o <= 1'b0;
    end else if (en) begin
      v1_q        <= in_valid_i;
      v2_q        <= v1_q;
      v3_q        <= v2_q;
      dv_q        <= {dv_q[QW-2:0], v3_q};
      v4_q        <= dv_q[QW-1];
      v5_q        <= v4_q;
      fv_q        <= {fv_q[DW-2:0], v5_q};
      v6_q        <= fv_q[DW-1];
      v7_q        <= v6_q;
      v8_q        <= v7_q;
      out_valid_o <= v8_q;
    end
  end

endmodule

[rtl/svpwm_checker.sv]
// Port-level checker for the SVPWM duty block, bound to the top level.
// Depends on svpwm_pkg and space_vector_pwm_duty_top_assert.svh.
`include "space_vector_pwm_duty_top_assert.svh"

module svpwm_checker (
  input logic                                       clk_i,
  input logic                                       rst_ni,
  input logic                                       in_valid_i,
  input logic                                       in_ready_o,
  input logic signed [svpwm_pkg::VOLTAGE_WIDTH-1:0] alpha_voltage_i,
  input logic signed [svpwm_pkg::VOLTAGE_WIDTH-1:0] beta_voltage_i,
  input logic        [svpwm_pkg::BUS_WIDTH-1:0]     bus_voltage_i,
  input logic                                       out_valid_o,
  input logic                                       out_ready_i,
  input logic        [svpwm_pkg::DUTY_WIDTH-1:0]    duty_a_o,
  input logic        [svpwm_pkg::DUTY_WIDTH-1:0]    duty_b_o,
  input logic        [svpwm_pkg::DUTY_WIDTH-1:0]    duty_c_o,
  input logic        [2:0]                          sector_o,
  input logic                                       overmodulated_o
);
  import svpwm_pkg::*;

  localparam logic [DUTY_WIDTH-1:0] ZV = DUTY_WIDTH'(ZERO_VEC_DUTY);

  // a waiting input beat stays offered with its payload unchanged
  `SVPWM_ASSERT_NXT(a_in_hold, in_valid_i && !in_ready_o, in_valid_i && $stable(alpha_voltage_i) && $stable(beta_voltage_i) && $stable(bus_voltage_i))

  // a stalled result beat stays offered
  `SVPWM_ASSERT_NXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o)

  // zero vector: all phases at the zero-vector duty, no scaling
  `SVPWM_ASSERT_IMP(a_zero_vec, out_valid_o && (sector_o == SEC_ZERO), (duty_a_o == ZV) && (duty_b_o == ZV) && (duty_c_o == ZV) && !overmodulated_o)

  // sector code seven never leaves the decoder
  `SVPWM_ASSERT_IMP(a_sector_rng, out_valid_o, sector_o != 3'd7)

  // input side opens whenever the result slot is free
  `SVPWM_ASSERT_IMP(a_ready_free, !out_valid_o, in_ready_o)

endmodule

bind space_vector_pwm_duty_top svpwm_checker u_svpwm_checker (.*);
